[hw/rtl/n_queens_solution_enumerator_unit_defines.svh]
// Assertion macros shared by the N-queens enumerator modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_UNIT_DEFINES_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NQSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define NQSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/nqse_pkg.sv]
// Package of the N-queens enumerator: field widths, constants and the
// command and status types between controller and datapath. No dependencies.
package nqse_pkg;

  localparam int NQSE_MAX_N     = 8;   // largest board the search supports
  localparam int NQSE_OUT_COLS  = 8;   // column fields carried by a result
  localparam int NQSE_BS_W      = 4;   // board size register width
  localparam int NQSE_ROW_W     = 4;   // row plus one field width
  localparam int NQSE_SOL_W     = 7;   // solution number width
  localparam int NQSE_TST_W     = 16;  // test counter width

  localparam logic [NQSE_BS_W-1:0]  NQSE_BOARD_RESET = 4'd8;
  localparam logic [NQSE_TST_W-1:0] NQSE_TST_MAX     = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_load;  // take a new board size, then clear the search
    logic clear;     // clear the search
    logic step;      // one iteration of the backtracking loop
    logic lift;      // take the queen of the current row off the board
  } nqse_cmd_t;

  // Status from the datapath, valid for a step issued in this cycle.
  typedef struct packed {
    logic emits;  // the step produces a result
    logic backs;  // the step moves up a row, so a lift must follow
  } nqse_stat_t;

endpackage

[hw/rtl/nqse_if.sv]
// Channel interfaces of the N-queens enumerator: request, result and
// configuration write. Depends on nqse_pkg for the payload widths.

interface nqse_req_if import nqse_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface nqse_res_if import nqse_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [NQSE_ROW_W-1:0] row_of_col0;
  logic [NQSE_ROW_W-1:0] row_of_col1;
  logic [NQSE_ROW_W-1:0] row_of_col2;
  logic [NQSE_ROW_W-1:0] row_of_col3;
  logic [NQSE_ROW_W-1:0] row_of_col4;
  logic [NQSE_ROW_W-1:0] row_of_col5;
  logic [NQSE_ROW_W-1:0] row_of_col6;
  logic [NQSE_ROW_W-1:0] row_of_col7;
  logic [NQSE_SOL_W-1:0] solution_number;
  logic [NQSE_TST_W-1:0] tests_since_last;
  logic                  search_done;

  modport source (output valid, output row_of_col0, output row_of_col1,
                  output row_of_col2, output row_of_col3, output row_of_col4,
                  output row_of_col5, output row_of_col6, output row_of_col7,
                  output solution_number, output tests_since_last,
                  output search_done, input ready);
  modport sink   (input valid, input row_of_col0, input row_of_col1,
                  input row_of_col2, input row_of_col3, input row_of_col4,
                  input row_of_col5, input row_of_col6, input row_of_col7,
                  input solution_number, input tests_since_last,
                  input search_done, output ready);
endinterface

interface nqse_cfg_if import nqse_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NQSE_BS_W-1:0] board_size;

  modport source (output valid, output board_size, input ready);
  modport sink   (input valid, input board_size, output ready);
endinterface

[hw/rtl/nqse_dp.sv]
// Datapath of the N-queens enumerator: occupancy flags, per-row stack,
// counters and the result register. Depends on nqse_pkg and the macro header.
`include "n_queens_solution_enumerator_unit_defines.svh"

module nqse_dp import nqse_pkg::*; #(
  parameter int MAX_N = NQSE_MAX_N
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  nqse_cmd_t                                cmd,
  input  logic [NQSE_BS_W-1:0]                     cfg_board_size,
  output nqse_stat_t                               stat,
  output logic [NQSE_OUT_COLS-1:0][NQSE_ROW_W-1:0] res_rows,
  output logic [NQSE_SOL_W-1:0]                    res_sol,
  output logic [NQSE_TST_W-1:0]                    res_tests,
  output logic                                     res_done
);

  localparam int LW  = $clog2(MAX_N + 1);  // holds 0..MAX_N
  localparam int RIW = $clog2(MAX_N);      // row or column index
  localparam int DW  = 2 * MAX_N - 1;      // diagonals on the board
  localparam int DIW = $clog2(DW);
  localparam int DPW = 2 ** DIW;           // diagonal vector padded to its index range

  logic [NQSE_BS_W-1:0]          board_size_r, board_size_nxt;
  logic [MAX_N-1:0]              col_used_r, col_used_nxt;
  logic [DW-1:0]                 rdiag_r, rdiag_nxt;
  logic [DW-1:0]                 fdiag_r, fdiag_nxt;
  logic [MAX_N-1:0][LW-1:0]      next_col_r, next_col_nxt;
  logic [MAX_N-1:0][LW-1:0]      queen_row_r, queen_row_nxt;
  logic [LW-1:0]                 level_r, level_nxt;
  logic [NQSE_SOL_W-1:0]         sol_r, sol_nxt;
  logic [NQSE_TST_W-1:0]         tcnt_r, tcnt_nxt;
  logic                          exh_r, exh_nxt;

  logic [NQSE_OUT_COLS-1:0][NQSE_ROW_W-1:0] rows_r, rows_nxt;
  logic [NQSE_SOL_W-1:0]         out_sol_r;
  logic [NQSE_TST_W-1:0]         out_tests_r, tests_emit;
  logic                          out_done_r, done_nxt, load_out;

  logic [LW-1:0]                 n;
  logic [RIW-1:0]                ri, ci, lci, col_sel;
  logic [LW-1:0]                 cval, lift_col, lvl_inc;
  logic                          held, row_end, free;
  logic [DIW-1:0]                rise_idx, fall_idx;
  logic [DIW-1:0]                rise_tst, fall_tst;
  logic [DPW-1:0]                rdiag_pad, fdiag_pad, rd_pad_nxt, fd_pad_nxt;

  // Board edge in use: zero acts as one, anything above MAX_N as MAX_N.
  always_comb begin
    if (board_size_r == '0) begin
      n = LW'(1);
    end else if (board_size_r > NQSE_BS_W'(MAX_N)) begin
      n = LW'(MAX_N);
    end else begin
      n = LW'(board_size_r);
    end
  end

  // Square under test, or the queen to lift, in the row at the current level.
  assign held     = (level_r >= n);
  assign ri       = level_r[RIW-1:0];
  assign cval     = next_col_r[ri];
  assign row_end  = (cval >= n);
  assign ci       = cval[RIW-1:0];
  assign lift_col = cval - LW'(1);
  assign lci      = lift_col[RIW-1:0];
  assign col_sel  = cmd.lift ? lci : ci;
  assign rise_idx = DIW'(col_sel) + DIW'(MAX_N - 1) - DIW'(ri);
  assign fall_idx = DIW'(ri) + DIW'(col_sel);
  // The square test looks only at registers, so the status never waits on a command.
  assign rise_tst = DIW'(ci) + DIW'(MAX_N - 1) - DIW'(ri);
  assign fall_tst = DIW'(ri) + DIW'(ci);
  assign rdiag_pad = DPW'(rdiag_r);
  assign fdiag_pad = DPW'(fdiag_r);
  assign free     = !col_used_r[ci] && !rdiag_pad[rise_tst] && !fdiag_pad[fall_tst];
  assign lvl_inc  = level_r + LW'(1);

  assign stat.emits = exh_r || (!held && (row_end ? (level_r == '0)
                                                  : (free && lvl_inc == n)));
  assign stat.backs = !exh_r && (held || (row_end && level_r != '0));

  always_comb begin
    board_size_nxt = board_size_r;
    col_used_nxt   = col_used_r;
    rd_pad_nxt     = rdiag_pad;
    fd_pad_nxt     = fdiag_pad;
    next_col_nxt   = next_col_r;
    queen_row_nxt  = queen_row_r;
    level_nxt      = level_r;
    sol_nxt        = sol_r;
    tcnt_nxt       = tcnt_r;
    exh_nxt        = exh_r;
    load_out       = 1'b0;
    done_nxt       = 1'b0;

    if (cmd.cfg_load) begin
      board_size_nxt = cfg_board_size;
    end

    if (cmd.cfg_load || cmd.clear) begin
      col_used_nxt  = '0;
      rd_pad_nxt    = '0;
      fd_pad_nxt    = '0;
      next_col_nxt  = '0;
      queen_row_nxt = '0;
      level_nxt     = '0;
      sol_nxt       = '0;
      tcnt_nxt      = '0;
      exh_nxt       = 1'b0;
    end else if (cmd.lift) begin
      col_used_nxt[lci]   = 1'b0;
      rd_pad_nxt[rise_idx] = 1'b0;
      fd_pad_nxt[fall_idx] = 1'b0;
      queen_row_nxt[lci]  = '0;
    end else if (cmd.step) begin
      if (exh_r) begin
        load_out = 1'b1;
        done_nxt = 1'b1;
      end else if (held) begin
        // A solution is on the board: drop back to its last row.
        level_nxt = n - LW'(1);
      end else if (row_end) begin
        next_col_nxt[ri] = '0;
        if (level_r == '0) begin
          exh_nxt  = 1'b1;
          load_out = 1'b1;
          done_nxt = 1'b1;
        end else begin
          level_nxt = level_r - LW'(1);
        end
      end else begin
        if (tcnt_r != NQSE_TST_MAX) begin
          tcnt_nxt = tcnt_r + NQSE_TST_W'(1);
        end
        next_col_nxt[ri] = cval + LW'(1);
        if (free) begin
          col_used_nxt[ci]     = 1'b1;
          rd_pad_nxt[rise_idx] = 1'b1;
          fd_pad_nxt[fall_idx] = 1'b1;
          queen_row_nxt[ci]    = lvl_inc;
          level_nxt            = lvl_inc;
          if (lvl_inc == n) begin
            sol_nxt  = sol_r + NQSE_SOL_W'(1);
            load_out = 1'b1;
          end
        end
      end
    end

    // Every result hands over the running test count and restarts it.
    tests_emit = tcnt_nxt;
    if (load_out) begin
      tcnt_nxt = '0;
    end
  end

  assign rdiag_nxt = rd_pad_nxt[DW-1:0];
  assign fdiag_nxt = fd_pad_nxt[DW-1:0];

  for (genvar j = 0; j < NQSE_OUT_COLS; j++) begin : g_rows
    if (j < MAX_N) begin : g_used
      assign rows_nxt[j] = done_nxt ? '0 : NQSE_ROW_W'(queen_row_nxt[j]);
    end else begin : g_unused
      assign rows_nxt[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= NQSE_BOARD_RESET;
      col_used_r   <= '0;
      rdiag_r      <= '0;
      fdiag_r      <= '0;
      next_col_r   <= '0;
      queen_row_r  <= '0;
      level_r      <= '0;
      sol_r        <= '0;
      tcnt_r       <= '0;
      exh_r        <= 1'b0;
    end else begin
      board_size_r <= board_size_nxt;
      col_used_r   <= col_used_nxt;
      rdiag_r      <= rdiag_nxt;
      fdiag_r      <= fdiag_nxt;
      next_col_r   <= next_col_nxt;
      queen_row_r  <= queen_row_nxt;
      level_r      <= level_nxt;
      sol_r        <= sol_nxt;
      tcnt_r       <= tcnt_nxt;
      exh_r        <= exh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rows_r      <= rows_nxt;
      out_sol_r   <= sol_nxt;
      out_tests_r <= tests_emit;
      out_done_r  <= done_nxt;
    end
  end

  assign res_rows  = rows_r;
  assign res_sol   = out_sol_r;
  assign res_tests = out_tests_r;
  assign res_done  = out_done_r;

  `NQSE_ASSERT_IMPL(a_level_range, 1'b1, level_r <= LW'(MAX_N), "search level beyond board")
  `NQSE_ASSERT_IMPL(a_exh_empty, exh_r, level_r == '0 && col_used_r == '0, "exhausted with queens left")
  `NQSE_ASSERT_IMPL(a_sol_full, load_out && !done_nxt, $countones(col_used_nxt) == int'(n), "solution without full board")

endmodule

[hw/rtl/nqse_ctrl.sv]
// Controller of the N-queens enumerator: handshakes and the step/lift
// sequencer. Depends on nqse_pkg and the macro header.
`include "n_queens_solution_enumerator_unit_defines.svh"

module nqse_ctrl import nqse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  nqse_stat_t stat,
  input  logic       in_valid,
  input  logic       in_restart,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output nqse_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_LIFT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    cfg_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.cfg_load = cfg_valid;
        if (in_valid) begin
          cmd.clear = in_restart;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.emits) begin
          if (out_free) begin
            cmd.step  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
          if (stat.backs) begin
            state_nxt = S_LIFT;
          end
        end
      end
      S_LIFT: begin
        cmd.lift  = 1'b1;
        state_nxt = S_STEP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (cmd.step && stat.emits);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `NQSE_ASSERT_IMPL(a_emit_space, cmd.step && stat.emits, out_free, "result over a pending result")
  `NQSE_ASSERT_NEXT(a_lift_follows, cmd.step && stat.backs, cmd.lift, "backtrack without lift")
  `NQSE_ASSERT_IMPL(a_one_op, cmd.step || cmd.lift, !(cmd.step && cmd.lift) && !cmd.clear && !cmd.cfg_load, "overlapping datapath commands")

endmodule

[hw/rtl/n_queens_solution_enumerator_unit.sv]
// Top level of the N-queens solution enumerator: joins the controller and
// the datapath. Depends on nqse_pkg, the nqse_if interfaces, nqse_ctrl, nqse_dp.
//
//   Channel  Direction  Payload                                   Transfer when
//   cfg_ch   in         board_size                                valid & ready
//   in_ch    in         restart                                   valid & ready
//   out_ch   out        row_of_col0..7, solution_number,          valid & ready
//                       tests_since_last, search_done
//
// A request is taken while the controller is idle; the search then makes one step
// per square test, plus a step for each row left exhausted and a lift of the queen
// above it, plus a step and a lift to reopen a held solution.
// Reset (rst_n low, synchronous) sets an 8 board and an empty search.
// A finished result waits in the output register; the search stalls only when
// it has the next result ready and that register is still full.
//
// The search is a depth-first walk held in flip-flops: column, rising-diagonal
// and falling-diagonal occupancy flags, and for each row the next column to
// test. Rows fill from row 0 upward and each row tries columns from low to
// high. Taking a queen off (a lift) happens in the cycle after the level drops,
// so the row stack is only ever read and written at the current level.
// A restart request, or any write of the board size, clears the whole search.
// Once every placement has been tried, each request returns a done result
// until the search is cleared again.

module n_queens_solution_enumerator_unit import nqse_pkg::*; #(
  parameter int MAX_N = NQSE_MAX_N
) (
  input  logic          clk,
  input  logic          rst_n,
  nqse_cfg_if.sink      cfg_ch,
  nqse_req_if.sink      in_ch,
  nqse_res_if.source    out_ch
);

  nqse_cmd_t  cmd;
  nqse_stat_t stat;

  logic [NQSE_OUT_COLS-1:0][NQSE_ROW_W-1:0] res_rows;
  logic [NQSE_SOL_W-1:0]                    res_sol;
  logic [NQSE_TST_W-1:0]                    res_tests;
  logic                                     res_done;

  // The controller owns every handshake and sequences the search.
  nqse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cmd        (cmd)
  );

  // The datapath holds the board, the row stack, the counters and the
  // result register that drives the output payload.
  nqse_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_board_size (cfg_ch.board_size),
    .stat           (stat),
    .res_rows       (res_rows),
    .res_sol        (res_sol),
    .res_tests      (res_tests),
    .res_done       (res_done)
  );

  assign out_ch.row_of_col0      = res_rows[0];
  assign out_ch.row_of_col1      = res_rows[1];
  assign out_ch.row_of_col2      = res_rows[2];
  assign out_ch.row_of_col3      = res_rows[3];
  assign out_ch.row_of_col4      = res_rows[4];
  assign out_ch.row_of_col5      = res_rows[5];
  assign out_ch.row_of_col6      = res_rows[6];
  assign out_ch.row_of_col7      = res_rows[7];
  assign out_ch.solution_number  = res_sol;
  assign out_ch.tests_since_last = res_tests;
  assign out_ch.search_done      = res_done;

endmodule
